[hw/rtl/unique_id_fifo_with_removal_macros.svh]
// ----------------------------------------------------------------------------
// Identifier queue assertion macros
// Shared clocked assertion forms; the user supplies clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ID_FIFO_WITH_REMOVAL_MACROS_SVH
`define UNIQUE_ID_FIFO_WITH_REMOVAL_MACROS_SVH

// property that holds at every edge outside reset
`define UIDFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define UIDFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/uidfr_pkg.sv]
// ----------------------------------------------------------------------------
// uidfr_pkg
// Shared constants, operation codes and result type of the identifier queue.
// ----------------------------------------------------------------------------
package uidfr_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int ID_WIDTH_DEF = 16;

	// fixed field widths
	localparam int ID_PORT_W = 16;
	localparam int CFG_W     = 5;
	localparam int POS_W     = 4;
	localparam int QLEN_W    = 5;

	localparam logic [CFG_W-1:0] SLOT_COUNT_RST = CFG_W'(16);

	// operation codes
	localparam logic [1:0] FUNC_ENQ = 2'd0;
	localparam logic [1:0] FUNC_REM = 2'd1;
	localparam logic [1:0] FUNC_POP = 2'd2;
	localparam logic [1:0] FUNC_QRY = 2'd3;

	typedef struct packed {
		logic                 ok;
		logic [ID_PORT_W-1:0] popped_id;
		logic [POS_W-1:0]     position;
		logic [QLEN_W-1:0]    queue_length;
		logic                 has_open_slot;
	} res_t;

endpackage

[hw/rtl/uidfr_mem.sv]
// ----------------------------------------------------------------------------
// uidfr_mem
// Entry store: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module uidfr_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/uidfr_engine.sv]
// ----------------------------------------------------------------------------
// uidfr_engine
// Sequencer around one compare and copy path: scans the store, then
// appends, closes a gap by copying entries down, or reports a position.
// ----------------------------------------------------------------------------
`include "unique_id_fifo_with_removal_macros.svh"

module uidfr_engine
	import uidfr_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF,
	localparam int SW      = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W,
	localparam int AW      = $clog2(DEPTH),
	localparam int LW      = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           start_func,
	input  logic [ID_PORT_W-1:0] start_id,
	input  logic [CFG_W-1:0]     slot_count,
	output logic                 idle,
	output logic                 res_valid,
	input  logic                 res_take,
	output res_t                 res,
	output logic                 mem_we,
	output logic [AW-1:0]        mem_waddr,
	output logic [SW-1:0]        mem_wdata,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [SW-1:0]        mem_rdata
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_SHIFT  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]    state_q;
	logic [LW-1:0] len_q;
	logic [1:0]    func_q;
	logic [SW-1:0] id_q;
	logic [SW-1:0] head_q;
	logic          found_q;
	logic [AW-1:0] fidx_q;
	logic          ok_q;
	logic [LW-1:0] lim_q;
	logic [LW-1:0] rd_idx_q;
	logic          rv_s1;
	logic [LW-1:0] ri_s1;

	logic [LW-1:0] cap;
	logic          issue;
	logic          hit;
	logic          id_ok;
	logic          enq_ok;
	logic [LW-1:0] wr_back;

	// capacity: slot count saturated to the store depth
	always_comb begin
		if (int'(slot_count) < DEPTH) begin
			cap = LW'(slot_count);
		end else begin
			cap = LW'(DEPTH);
		end
	end

	assign issue   = (state_q == ST_SCAN || state_q == ST_SHIFT) && (rd_idx_q < lim_q);
	assign hit     = rv_s1 && ((func_q == FUNC_POP) || (mem_rdata == id_q));
	assign id_ok   = (id_q != '0);
	assign enq_ok  = id_ok && (len_q < cap) && !found_q;
	assign wr_back = ri_s1 - LW'(1);

	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q[AW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_back[AW-1:0];
		mem_wdata = mem_rdata;
		if (state_q == ST_SHIFT) begin
			mem_we = rv_s1;
		end else if (state_q == ST_DECIDE && func_q == FUNC_ENQ) begin
			mem_we    = enq_ok;
			mem_waddr = len_q[AW-1:0];
			mem_wdata = id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			rv_s1    <= 1'b0;
			found_q  <= 1'b0;
			ok_q     <= 1'b0;
			rd_idx_q <= '0;
			lim_q    <= '0;
		end else begin
			rv_s1 <= issue;
			ri_s1 <= rd_idx_q;
			if (issue) begin
				rd_idx_q <= rd_idx_q + LW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q   <= start_func;
						id_q     <= start_id[SW-1:0];
						found_q  <= 1'b0;
						ok_q     <= 1'b0;
						rd_idx_q <= '0;
						// pop looks at the head only
						if (start_func == FUNC_POP) begin
							lim_q <= (len_q != '0) ? LW'(1) : '0;
						end else begin
							lim_q <= len_q;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit && !found_q) begin
						found_q <= 1'b1;
						fidx_q  <= ri_s1[AW-1:0];
						head_q  <= mem_rdata;
					end
					if (!issue && !rv_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
					case (func_q)
						FUNC_ENQ: begin
							if (enq_ok) begin
								len_q <= len_q + LW'(1);
								ok_q  <= 1'b1;
							end
						end
						FUNC_QRY: begin
							ok_q <= id_ok && found_q && (int'(fidx_q) < int'(slot_count));
						end
						default: begin
							// remove or pop: copy later entries down one place
							if (found_q && (id_ok || func_q == FUNC_POP)) begin
								ok_q     <= 1'b1;
								rd_idx_q <= LW'(fidx_q) + LW'(1);
								lim_q    <= len_q;
								state_q  <= ST_SHIFT;
							end
						end
					endcase
				end
				ST_SHIFT: begin
					if (!issue && !rv_s1) begin
						len_q   <= len_q - LW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res               = '0;
		res.ok            = ok_q;
		res.queue_length  = QLEN_W'(len_q);
		res.has_open_slot = (len_q < cap);
		if (ok_q && func_q == FUNC_POP) begin
			res.popped_id = ID_PORT_W'(head_q);
		end
		if (ok_q && func_q == FUNC_QRY) begin
			res.position = POS_W'(fidx_q);
		end
	end

	`UIDFR_ASSERT_NEXT(a_len_only_on_update, state_q == ST_IDLE || state_q == ST_SCAN || state_q == ST_DONE, $stable(len_q), "queue length moved outside an update")
	`UIDFR_ASSERT(a_no_write_in_scan, (state_q != ST_SCAN) || !mem_we, "store written during scan")
	`UIDFR_ASSERT(a_found_below_len, (state_q != ST_DECIDE) || !found_q || (LW'(fidx_q) < len_q), "match index beyond queue length")

endmodule

[hw/rtl/unique_id_fifo_with_removal.sv]
// ----------------------------------------------------------------------------
// unique_id_fifo_with_removal
// Ordered queue of unique nonzero identifiers with enqueue, remove anywhere,
// pop head and position query; every result reports length and free slot.
// ----------------------------------------------------------------------------
// Channel  Handshake                    Payload
// in       in_valid / in_ready          func, guest_id
// out      out_valid / out_ready        ok, popped_id, position, queue_length,
//                                       has_open_slot
// cfg      cfg_we (no wait)             cfg_wdata -> slot_count
//
// One request at a time: the next is accepted only once the previous result
// has moved to the output register; remove and pop add a copy-down step.
// Scan and gap closing both go through the single read port of the store.
// Reset clears the length and sets the slot count to 16; the store is not
// cleared, as only entries below the length are ever read.
// in_ready drops on accept; a second result waits in the sequencer while the
// first is held in the output register by out_ready.
// ----------------------------------------------------------------------------
`include "unique_id_fifo_with_removal_macros.svh"

module unique_id_fifo_with_removal
	import uidfr_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF,
	localparam int SW      = (ID_WIDTH < ID_PORT_W) ? ID_WIDTH : ID_PORT_W,
	localparam int AW      = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [ID_PORT_W-1:0] guest_id,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 ok,
	output logic [ID_PORT_W-1:0] popped_id,
	output logic [POS_W-1:0]     position,
	output logic [QLEN_W-1:0]    queue_length,
	output logic                 has_open_slot,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	logic [CFG_W-1:0] slot_count_q;
	logic             out_valid_q;
	res_t             res_q;

	logic             eng_idle;
	logic             eng_res_valid;
	logic             res_take;
	res_t             eng_res;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [SW-1:0]    mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [SW-1:0]    mem_rdata;

	// slot count register; write only while idle (the block does not enforce this)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	assign in_ready = eng_idle;

	// output register frees when empty or being taken this cycle
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eng_res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && res_take) begin
			res_q <= eng_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = res_q.ok;
	assign popped_id     = res_q.popped_id;
	assign position      = res_q.position;
	assign queue_length  = res_q.queue_length;
	assign has_open_slot = res_q.has_open_slot;

	uidfr_engine #(
		.DEPTH    (DEPTH),
		.ID_WIDTH (ID_WIDTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && in_ready),
		.start_func (func),
		.start_id   (guest_id),
		.slot_count (slot_count_q),
		.idle       (eng_idle),
		.res_valid  (eng_res_valid),
		.res_take   (res_take),
		.res        (eng_res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	uidfr_mem #(
		.DEPTH (DEPTH),
		.WIDTH (SW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	`UIDFR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

[tb/sv/id_queue_monitor.sv]
// ----------------------------------------------------------------------------
// id_queue_monitor
// Watches the request, result and register ports of the identifier queue.
// Predicts each result from a shadow copy of the queue and compares it with
// the block's output; hands the running fault count and backlog to the top.
// ----------------------------------------------------------------------------
module id_queue_monitor
	import uidfr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [ID_PORT_W-1:0] guest_id,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 ok,
	input  logic [ID_PORT_W-1:0] popped_id,
	input  logic [POS_W-1:0]     position,
	input  logic [QLEN_W-1:0]    queue_length,
	input  logic                 has_open_slot,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   mismatches,
	output int                   results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 10;

	logic [CFG_W-1:0]     slots;
	logic [ID_PORT_W-1:0] shadow_ids[$];	// index 0 is the head
	res_t                 pending_results[$];
	int                   fault_count;

	// apply one request to the shadow queue, return what the block should say
	function automatic res_t apply_request(input logic [1:0] op,
			input logic [ID_PORT_W-1:0] id);
		res_t r;
		int   at;
		int   cap;
		r   = '0;
		at  = -1;
		cap = (slots > DEPTH_DEF) ? DEPTH_DEF : int'(slots);
		foreach (shadow_ids[i])
			if (at < 0 && shadow_ids[i] == id)
				at = i;
		case (op)
			FUNC_ENQ: begin
				if (id != '0 && shadow_ids.size() < cap && at < 0) begin
					shadow_ids.push_back(id);
					r.ok = 1'b1;
				end
			end
			FUNC_REM: begin
				if (id != '0 && at >= 0) begin
					shadow_ids.delete(at);
					r.ok = 1'b1;
				end
			end
			FUNC_POP: begin
				if (shadow_ids.size() > 0) begin
					r.popped_id = shadow_ids.pop_front();
					r.ok        = 1'b1;
				end
			end
			default: begin
				// found beyond the slot count still fails
				if (id != '0 && at >= 0 && at < int'(slots)) begin
					r.position = POS_W'(at);
					r.ok       = 1'b1;
				end
			end
		endcase
		r.queue_length  = QLEN_W'(shadow_ids.size());
		r.has_open_slot = shadow_ids.size() < cap;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			slots = SLOT_COUNT_RST;
			shadow_ids.delete();
			pending_results.delete();
			fault_count = 0;
		end else begin
			if (cfg_we)
				slots = cfg_wdata;
			// results first: a request taken at this edge cannot answer here
			if (out_valid && out_ready) begin
				got = {ok, popped_id, position, queue_length, has_open_slot};
				if (pending_results.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("%0t: result with none due: ok=%0d popped=%h pos=%0d len=%0d open=%0d",
							$realtime, got.ok, got.popped_id, got.position,
							got.queue_length, got.has_open_slot);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= REPORT_MAX)
							$display("%0t: mismatch exp ok=%0d popped=%h pos=%0d len=%0d open=%0d | got ok=%0d popped=%h pos=%0d len=%0d open=%0d",
								$realtime, want.ok, want.popped_id, want.position,
								want.queue_length, want.has_open_slot, got.ok,
								got.popped_id, got.position, got.queue_length,
								got.has_open_slot);
					end
				end
			end
			if (in_valid && in_ready)
				pending_results.push_back(apply_request(func, guest_id));
		end
		mismatches  <= fault_count;
		results_due <= pending_results.size();
	end

endmodule

[tb/sv/tb_unique_id_fifo_with_removal.sv]
// ----------------------------------------------------------------------------
// tb_unique_id_fifo_with_removal
// Drives requests and slot-count settings into the identifier queue, with
// random idling on both channels; the monitor predicts and checks results.
// ----------------------------------------------------------------------------
module tb_unique_id_fifo_with_removal;
	import uidfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 270;	// ~1890 random requests in all
	localparam int POOL_SIZE   = 24;
	// slowest request: a remove, scan then copy down; random stalls on either
	// side add to it. Quiet stretches also cover register writes between phases.
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 2 * DEPTH_DEF + 8;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [1:0]           func          = FUNC_ENQ;
	logic [ID_PORT_W-1:0] guest_id      = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 ok;
	logic [ID_PORT_W-1:0] popped_id;
	logic [POS_W-1:0]     position;
	logic [QLEN_W-1:0]    queue_length;
	logic                 has_open_slot;
	logic                 cfg_we        = 1'b0;
	logic [CFG_W-1:0]     cfg_wdata     = '0;

	int                   mismatches;
	int                   results_due;
	int                   quiet_cycles  = 0;
	bit                   hold_steady   = 1'b0;	// no idling on either side
	logic [ID_PORT_W-1:0] id_pool[POOL_SIZE];

	unique_id_fifo_with_removal dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.guest_id     (guest_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ok           (ok),
		.popped_id    (popped_id),
		.position     (position),
		.queue_length (queue_length),
		.has_open_slot(has_open_slot),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	id_queue_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.guest_id     (guest_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ok           (ok),
		.popped_id    (popped_id),
		.position     (position),
		.queue_length (queue_length),
		.has_open_slot(has_open_slot),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.results_due  (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: back-pressure about 27 percent of the time, none while holding steady
	always @(posedge clk) begin
		out_ready <= hold_steady || ($urandom_range(0, 99) >= 27);
	end

	// Present one request and hold it until taken. Returns at the accepting
	// edge with in_valid still high, so a following request just swaps the
	// payload and valid is never dropped and raised in the same step.
	task automatic send_request(input logic [1:0] op, input logic [ID_PORT_W-1:0] id);
		while (!hold_steady && $urandom_range(0, 99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= op;
		guest_id <= id;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drain, then write the slot count. Every request answers exactly once,
	// so an empty backlog means the block is idle. The extra edge lets the
	// monitor count a request taken at the edge we were called on.
	task automatic write_slot_count(input logic [CFG_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Watchdog: cycles with no handshake on either channel.
	initial begin
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int                   slot_plan[PHASES];
		int                   pick;
		logic [1:0]           op;
		logic [ID_PORT_W-1:0] id;

		slot_plan = '{16, 0, 5, 1, 12, 16, 9};
		slot_plan[PHASES-1] = $urandom_range(0, 16);

		// pool of identifiers so that requests often hit queued entries;
		// all-ones and single-bit ends included
		id_pool[0] = 16'hFFFF;
		id_pool[1] = 16'h0001;
		id_pool[2] = 16'h8000;
		for (int i = 3; i < POOL_SIZE; i++)
			id_pool[i] = ID_PORT_W'($urandom_range(1, 65535));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- directed ----------------
		write_slot_count(CFG_W'(16));

		// zero identifier, pop on empty, remove of an absent identifier, query of zero
		send_request(FUNC_ENQ, '0);
		send_request(FUNC_POP, '0);
		send_request(FUNC_REM, 16'h1234);
		send_request(FUNC_QRY, '0);

		// fill all sixteen slots; duplicate tried once along the way
		for (int i = 0; i < DEPTH_DEF; i++) begin
			send_request(FUNC_ENQ, (i == 0) ? 16'hFFFF : (16'h0001 << (i - 1)));
			if (i == 1)
				send_request(FUNC_ENQ, 16'hFFFF);
		end
		send_request(FUNC_ENQ, 16'h4242);	// full
		send_request(FUNC_QRY, 16'h4000);	// tail, position 15
		send_request(FUNC_REM, 16'h0001);	// close a gap near the head
		send_request(FUNC_POP, '0);
		send_request(FUNC_REM, '0);

		// slot count below length: queued entries stay, enqueue refused,
		// query past the slot count fails, query inside it still works
		write_slot_count(CFG_W'(4));
		send_request(FUNC_QRY, 16'h0400);
		send_request(FUNC_ENQ, 16'h1234);
		send_request(FUNC_QRY, 16'h0008);

		// ---------------- random phases ----------------
		for (int p = 0; p < PHASES; p++) begin
			write_slot_count(CFG_W'(slot_plan[p]));
			hold_steady = (p == 5);	// one long stretch with no idling
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					op = FUNC_ENQ;
				else if (pick < 60)
					op = FUNC_REM;
				else if (pick < 75)
					op = FUNC_POP;
				else
					op = FUNC_QRY;
				pick = $urandom_range(0, 99);
				if (pick < 5)
					id = '0;
				else if (pick < 15)
					id = ID_PORT_W'($urandom_range(0, 65535));
				else
					id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
				send_request(op, id);
			end
		end
		hold_steady = 1'b0;

		// ---------------- drain and verdict ----------------
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		// catch any stray extra result
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0 && results_due == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
